>>> src/skt_pkg.sv
// Shared types and constants of the sorted key table.
package skt_pkg;

  // Operation codes carried in the input beat.
  typedef enum logic [1:0] {
    OP_INSERT     = 2'd0,
    OP_FIND_EXACT = 2'd1,
    OP_FIND_ABOVE = 2'd2,
    OP_READ       = 2'd3
  } op_t;

  // Result status codes.
  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_NOT_FOUND = 2'd1,
    STS_FULL      = 2'd2
  } status_t;

  // Sequencer states, one-hot.
  typedef enum logic [8:0] {
    ST_IDLE       = 9'b000000001,
    ST_SEARCH     = 9'b000000010,
    ST_CMP        = 9'b000000100,
    ST_SHIFT      = 9'b000001000,
    ST_SHIFT_LAST = 9'b000010000,
    ST_WRITE      = 9'b000100000,
    ST_FETCH      = 9'b001000000,
    ST_CHECK      = 9'b010000000,
    ST_DONE       = 9'b100000000
  } state_t;

  // Widths of the packed stream fields.
  localparam int unsigned OP_W       = 2;
  localparam int unsigned KEY_W      = 32;
  localparam int unsigned HDL_W      = 32;
  localparam int unsigned IDX_W      = 6;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned POS_W      = 6;
  localparam int unsigned COUNT_W    = 7;
  localparam int unsigned IN_DATA_W  = 72;
  localparam int unsigned OUT_DATA_W = 80;

  // Widest stored key or handle, and a width that holds any table position.
  localparam int unsigned WIDE_W = 64;
  localparam int unsigned ADDR_EXT_W = 16;

endpackage

>>> src/sorted_key_table.sv
// Top level of the sorted key table: sequencer, search unit and result register.
//
// The table holds up to CAPACITY (key, handle) entries kept in ascending key
// order in a single-port-write, single-port-read memory. One beat on the slave
// stream carries an operation: insert, find exact key, find key at or above,
// or read the entry at an index. Each accepted beat produces exactly one beat
// on the master stream, carrying status, position, key, handle and the entry
// count after the operation.
// The block works on one beat at a time and holds s_tready low while busy.
// A lower-bound search alternates a search and a compare state for each halving
// step and closes in the search state, with the memory read port and one key
// comparator shared across steps. An insert then moves every later entry up by
// one at one entry per cycle and writes the new entry in the write state. A find
// whose position lies below the count, and a read within the count, go through
// a fetch and a check state. Every item also passes through the final state and
// the idle state in which its beat is accepted.
// Results are held in an output register: the next beat is accepted while a
// finished result still waits, and the sequencer waits in its final state if
// the receiver stalls with a result still pending.
// Reset empties the table by clearing the entry count; memory contents are
// left as they are, since no position at or above the count is ever read.
module sorted_key_table
  import skt_pkg::*;
#(
  parameter int unsigned CAPACITY     = 64,
  parameter int unsigned KEY_WIDTH    = 32,
  parameter int unsigned HANDLE_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // operation[1:0], key[33:2], handle[65:34], index[71:66]
  input  logic [IN_DATA_W-1:0]  s_tdata,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // status[1:0], position[7:2], found_key[39:8], found_handle[71:40],
  // entry_count[78:72], zero padding above
  output logic [OUT_DATA_W-1:0] m_tdata
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned EW = KEY_WIDTH + HANDLE_WIDTH;

  state_t state;

  // Input item, held for the whole operation.
  op_t                     op;
  logic [KEY_WIDTH-1:0]    kin;
  logic [HANDLE_WIDTH-1:0] hin;

  // Search window, shift pointer and table count.
  logic [CW-1:0] lo;
  logic [CW-1:0] hi;
  logic [CW-1:0] count;
  logic [AW-1:0] pos;
  logic [AW-1:0] sh;
  logic [AW-1:0] wr_addr;
  logic          wr_pend;

  // Pending result, moved into the output register in the final state.
  status_t                 res_status;
  logic [KEY_WIDTH-1:0]    res_key;
  logic [HANDLE_WIDTH-1:0] res_hdl;

  // Output register fields.
  logic [STATUS_W-1:0] out_status;
  logic [POS_W-1:0]    out_pos;
  logic [KEY_W-1:0]    out_key;
  logic [HDL_W-1:0]    out_hdl;
  logic [COUNT_W-1:0]  out_count;

  // Unpacked input fields, widened so that any parameter value fits.
  logic [WIDE_W-1:0]     key_wide;
  logic [WIDE_W-1:0]     hdl_wide;
  logic [ADDR_EXT_W-1:0] idx_ext;
  logic [ADDR_EXT_W-1:0] count_ext;
  logic [ADDR_EXT_W-1:0] pos_ext;
  logic [WIDE_W-1:0]     res_key_wide;
  logic [WIDE_W-1:0]     res_hdl_wide;

  // Memory port and the shared comparator.
  logic                    ram_we;
  logic [AW-1:0]           ram_waddr;
  logic [EW-1:0]           ram_wdata;
  logic [AW-1:0]           ram_raddr;
  logic [EW-1:0]           ram_rdata;
  logic [KEY_WIDTH-1:0]    rd_key;
  logic [HANDLE_WIDTH-1:0] rd_hdl;
  logic [CW:0]             mid_sum;
  logic [AW-1:0]           mid;
  logic [CW-1:0]           count_m1;
  logic                    key_less;
  logic                    accept;

  assign key_wide  = {{(WIDE_W - KEY_W){1'b0}}, s_tdata[33:2]};
  assign hdl_wide  = {{(WIDE_W - HDL_W){1'b0}}, s_tdata[65:34]};
  assign idx_ext   = ADDR_EXT_W'(s_tdata[71:66]);
  assign count_ext = ADDR_EXT_W'(count);
  assign pos_ext   = ADDR_EXT_W'(pos);

  assign {rd_key, rd_hdl} = ram_rdata;
  assign mid_sum  = (CW + 1)'(lo) + (CW + 1)'(hi);
  assign mid      = mid_sum[AW:1];
  assign count_m1 = count - CW'(1);
  assign key_less = rd_key < kin;

  assign res_key_wide = WIDE_W'(res_key);
  assign res_hdl_wide = WIDE_W'(res_hdl);

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  // The read port follows the sequencer: the probe during the search, the
  // source entry during the shift, and the result entry otherwise.
  always_comb begin
    unique case (state)
      ST_SEARCH: ram_raddr = mid;
      ST_SHIFT:  ram_raddr = sh;
      default:   ram_raddr = pos;
    endcase
  end

  // Writes come from the shift pipeline or from the final placement.
  assign ram_we    = (state == ST_SHIFT && wr_pend) || (state == ST_SHIFT_LAST) ||
                     (state == ST_WRITE);
  assign ram_waddr = (state == ST_WRITE) ? pos : wr_addr;
  assign ram_wdata = (state == ST_WRITE) ? {kin, hin} : ram_rdata;

  skt_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (EW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Sequencer and control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      count    <= '0;
      wr_pend  <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      // The final state decides the valid flag itself when it hands over.
      if (m_tvalid && m_tready && state != ST_DONE) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            op  <= op_t'(s_tdata[1:0]);
            kin <= key_wide[KEY_WIDTH-1:0];
            hin <= hdl_wide[HANDLE_WIDTH-1:0];
            lo  <= '0;
            hi  <= count;
            priority if (op_t'(s_tdata[1:0]) == OP_READ) begin
              if (idx_ext >= count_ext) begin
                res_status <= STS_NOT_FOUND;
                pos        <= '0;
                res_key    <= '0;
                res_hdl    <= '0;
                state      <= ST_DONE;
              end else begin
                pos   <= idx_ext[AW-1:0];
                state <= ST_FETCH;
              end
            end else if (op_t'(s_tdata[1:0]) == OP_INSERT && count == CW'(CAPACITY)) begin
              res_status <= STS_FULL;
              pos        <= '0;
              res_key    <= '0;
              res_hdl    <= '0;
              state      <= ST_DONE;
            end else begin
              state <= ST_SEARCH;
            end
          end
        end
        ST_SEARCH: begin
          if (lo < hi) begin
            state <= ST_CMP;
          end else if (op == OP_INSERT) begin
            pos     <= lo[AW-1:0];
            sh      <= count_m1[AW-1:0];
            wr_pend <= 1'b0;
            state   <= (count > lo) ? ST_SHIFT : ST_WRITE;
          end else if (lo >= count) begin
            res_status <= STS_NOT_FOUND;
            pos        <= '0;
            res_key    <= '0;
            res_hdl    <= '0;
            state      <= ST_DONE;
          end else begin
            pos   <= lo[AW-1:0];
            state <= ST_FETCH;
          end
        end
        ST_CMP: begin
          if (key_less) begin
            lo <= CW'(mid) + CW'(1);
          end else begin
            hi <= CW'(mid);
          end
          state <= ST_SEARCH;
        end
        ST_SHIFT: begin
          // Each cycle reads one entry and writes the one read before it a
          // place higher.
          wr_pend <= 1'b1;
          wr_addr <= sh + AW'(1);
          if (sh == pos) begin
            state <= ST_SHIFT_LAST;
          end else begin
            sh <= sh - AW'(1);
          end
        end
        ST_SHIFT_LAST: begin
          wr_pend <= 1'b0;
          state   <= ST_WRITE;
        end
        ST_WRITE: begin
          count      <= count + CW'(1);
          res_status <= STS_OK;
          res_key    <= kin;
          res_hdl    <= hin;
          state      <= ST_DONE;
        end
        ST_FETCH: begin
          state <= ST_CHECK;
        end
        ST_CHECK: begin
          if (op == OP_FIND_EXACT && rd_key != kin) begin
            res_status <= STS_NOT_FOUND;
            pos        <= '0;
            res_key    <= '0;
            res_hdl    <= '0;
          end else begin
            res_status <= STS_OK;
            res_key    <= rd_key;
            res_hdl    <= rd_hdl;
          end
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Output payload register; loaded when the result leaves the final state.
  always_ff @(posedge clk) begin
    if (state == ST_DONE && (!m_tvalid || m_tready)) begin
      out_status <= res_status;
      out_pos    <= pos_ext[POS_W-1:0];
      out_key    <= res_key_wide[KEY_W-1:0];
      out_hdl    <= res_hdl_wide[HDL_W-1:0];
      out_count  <= count_ext[COUNT_W-1:0];
    end
  end

  assign m_tdata = {1'b0, out_count, out_hdl, out_key, out_pos, out_status};

  // The table never holds more than its capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("entry count above capacity");

  // The count only moves when the new entry is placed.
  a_count_stable: assert property (@(posedge clk) disable iff (rst)
    (state != ST_WRITE) |=> $stable(count))
    else $error("entry count changed outside placement");

  // The search window never inverts.
  a_window: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SEARCH || state == ST_CMP) |-> (lo <= hi))
    else $error("search window inverted");

  // The shift pointer never passes below the insert position.
  a_shift_ptr: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SHIFT) |-> (sh >= pos))
    else $error("shift pointer below insert position");

  // A placement always follows the end of a shift run.
  a_shift_end: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SHIFT_LAST) |=> (state == ST_WRITE))
    else $error("shift run not followed by placement");

endmodule

>>> src/skt_ram.sv
// Simple dual-port table memory with one write port and a registered read port.
module skt_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> bench/tb_sorted_key_table.sv
// Self-checking stream testbench for the sorted key table: directed and random traffic.
`timescale 1ns / 1ps

module tb_sorted_key_table;
  import skt_pkg::*;

  localparam int unsigned TABLE_DEPTH = 64;
  // Cycles with no beat on either side before the run is declared hung. The slowest
  // correct item is an insert at the front of a nearly full table, behind a full sender
  // gap and receiver stall.
  localparam int unsigned STALL_LIMIT = 4000;
  // Quiet cycles after the last reply, well beyond the longest insert.
  localparam int unsigned SETTLE_CYCLES = 200;

  typedef struct packed {
    op_t              op;
    logic [KEY_W-1:0] key;
    logic [HDL_W-1:0] hdl;
    logic [IDX_W-1:0] idx;
  } table_req_t;

  typedef struct packed {
    status_t             status;
    logic [POS_W-1:0]    pos;
    logic [KEY_W-1:0]    key;
    logic [HDL_W-1:0]    hdl;
    logic [COUNT_W-1:0]  count;
  } table_reply_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;

  // Shadow copy of the table, updated as each beat is accepted.
  logic [KEY_W-1:0] table_keys    [TABLE_DEPTH];
  logic [HDL_W-1:0] table_handles [TABLE_DEPTH];
  int unsigned      table_entries = 0;

  table_reply_t expected_replies[$];
  int unsigned  failures = 0;
  bit           steady_flow = 1'b0;

  always #1 clk = ~clk;

  sorted_key_table #(
    .CAPACITY     (TABLE_DEPTH),
    .KEY_WIDTH    (KEY_W),
    .HANDLE_WIDTH (HDL_W)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    // operation[1:0], key[33:2], handle[65:34], index[71:66]
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    // status[1:0], position[7:2], found_key[39:8], found_handle[71:40],
    // entry_count[78:72], zero padding above
    .m_tdata  (m_tdata)
  );

  // Lower-bound search over the occupied part of the shadow table.
  function automatic int unsigned first_not_below(logic [KEY_W-1:0] key);
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    lo = 0;
    hi = table_entries;
    while (lo < hi) begin
      mid = (lo + hi) / 2;
      if (table_keys[mid] < key) lo = mid + 1;
      else hi = mid;
    end
    return lo;
  endfunction

  // Applies one request to the shadow table and returns the reply it must produce.
  function automatic table_reply_t predict_table_op(table_req_t req);
    table_reply_t reply;
    int unsigned  at;
    reply = '0;
    reply.status = STS_NOT_FOUND;
    case (req.op)
      OP_INSERT: begin
        if (table_entries >= TABLE_DEPTH) begin
          reply.status = STS_FULL;
        end else begin
          at = first_not_below(req.key);
          for (int unsigned j = table_entries; j > at; j--) begin
            table_keys[j]    = table_keys[j - 1];
            table_handles[j] = table_handles[j - 1];
          end
          table_keys[at]    = req.key;
          table_handles[at] = req.hdl;
          table_entries++;
          reply.status = STS_OK;
          reply.pos    = at[POS_W-1:0];
          reply.key    = req.key;
          reply.hdl    = req.hdl;
        end
      end
      OP_FIND_EXACT, OP_FIND_ABOVE: begin
        at = first_not_below(req.key);
        if (at < table_entries && (req.op == OP_FIND_ABOVE || table_keys[at] == req.key)) begin
          reply.status = STS_OK;
          reply.pos    = at[POS_W-1:0];
          reply.key    = table_keys[at];
          reply.hdl    = table_handles[at];
        end
      end
      default: begin
        if (req.idx < table_entries) begin
          reply.status = STS_OK;
          reply.pos    = req.idx;
          reply.key    = table_keys[req.idx];
          reply.hdl    = table_handles[req.idx];
        end
      end
    endcase
    reply.count = table_entries[COUNT_W-1:0];
    return reply;
  endfunction

  // Drives one request beat after a random gap and records its reply once accepted.
  // Starts on the falling edge after the previous beat, so a zero gap keeps valid high.
  task automatic send_request(table_req_t req);
    int unsigned gap;
    gap = steady_flow ? 0 : $urandom_range(0, 4);
    @(negedge clk);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tdata  <= {req.idx, req.hdl, req.key, req.op};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (s_tready !== 1'b1);
    expected_replies.push_back(predict_table_op(req));
  endtask

  task automatic send_op(op_t op, logic [KEY_W-1:0] key, logic [HDL_W-1:0] hdl,
                         logic [IDX_W-1:0] idx);
    table_req_t req;
    req.op  = op;
    req.key = key;
    req.hdl = hdl;
    req.idx = idx;
    send_request(req);
  endtask

  // Drops valid and holds off until every outstanding reply has been checked.
  task automatic wait_until_drained();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (expected_replies.size() != 0) @(negedge clk);
  endtask

  // Random request biased towards keys already in the table, their neighbours and
  // the ends of the key range, so that exact finds hit and duplicates pile up.
  function automatic table_req_t random_request();
    table_req_t  req;
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (table_entries < TABLE_DEPTH) begin
      if (roll < 40)      req.op = OP_INSERT;
      else if (roll < 60) req.op = OP_FIND_EXACT;
      else if (roll < 80) req.op = OP_FIND_ABOVE;
      else                req.op = OP_READ;
    end else begin
      if (roll < 10)      req.op = OP_INSERT;
      else if (roll < 40) req.op = OP_FIND_EXACT;
      else if (roll < 70) req.op = OP_FIND_ABOVE;
      else                req.op = OP_READ;
    end
    roll = $urandom_range(0, 99);
    if (table_entries != 0 && roll >= 35 && roll < 70) begin
      req.key = table_keys[$urandom_range(0, table_entries - 1)];
      if (roll < 45)      req.key = req.key + 1;
      else if (roll < 55) req.key = req.key - 1;
    end else if (roll >= 70 && roll < 85) begin
      case ($urandom_range(0, 3))
        0:       req.key = '0;
        1:       req.key = 32'h0000_0001;
        2:       req.key = 32'hFFFF_FFFE;
        default: req.key = '1;
      endcase
    end else if (roll >= 85) begin
      req.key = {3'($urandom_range(0, 7)), 29'h0};
    end else begin
      req.key = $urandom();
    end
    req.hdl = $urandom();
    if (table_entries != 0 && $urandom_range(0, 9) < 6)
      req.idx = IDX_W'($urandom_range(0, table_entries - 1));
    else
      req.idx = IDX_W'($urandom_range(0, 63));
    return req;
  endfunction

  // Every kind of lookup against an empty table must miss.
  task automatic test_empty_table();
    send_op(OP_FIND_EXACT, '0, '0, '0);
    send_op(OP_FIND_ABOVE, '0, '1, '1);
    send_op(OP_FIND_ABOVE, '1, '0, '0);
    send_op(OP_READ, '0, '0, '0);
    send_op(OP_READ, '1, '1, '1);
  endtask

  // Front and back inserts, a duplicate key, hits and misses of both finds,
  // a search past the last entry and reads on either side of the count.
  task automatic test_directed_ops();
    send_op(OP_INSERT, 32'h8000_0000, 32'h1234_5678, '0);
    send_op(OP_INSERT, 32'h0000_0000, 32'h0000_0000, '1);
    send_op(OP_FIND_ABOVE, 32'h8000_0001, '0, '0);
    send_op(OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0);
    send_op(OP_INSERT, 32'h8000_0000, 32'hAAAA_AAAA, '0);
    send_op(OP_INSERT, 32'h5555_5555, 32'h5555_5555, '0);
    send_op(OP_FIND_EXACT, 32'h8000_0000, '0, '0);
    send_op(OP_FIND_EXACT, 32'h7FFF_FFFF, '0, '0);
    send_op(OP_FIND_EXACT, 32'h0000_0000, '0, '0);
    send_op(OP_FIND_EXACT, 32'hFFFF_FFFF, '0, '0);
    send_op(OP_FIND_ABOVE, 32'h0000_0001, '0, '0);
    send_op(OP_FIND_ABOVE, 32'h8000_0000, '0, '0);
    send_op(OP_FIND_ABOVE, 32'hFFFF_FFFF, '0, '0);
    send_op(OP_READ, '0, '0, 6'd0);
    send_op(OP_READ, '0, '0, 6'd4);
    send_op(OP_READ, '0, '0, 6'd5);
    send_op(OP_READ, '0, '0, 6'd63);
    send_op(OP_READ, '0, '0, 6'd2);
  endtask

  task automatic test_random_traffic(int unsigned n_items);
    repeat (n_items) send_request(random_request());
  endtask

  // Back-to-back beats with the receiver always ready.
  task automatic test_steady_stream(int unsigned n_items);
    steady_flow = 1'b1;
    test_random_traffic(n_items);
    steady_flow = 1'b0;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_empty_table();
    test_directed_ops();
    wait_until_drained();
    test_random_traffic(900);
    test_steady_stream(200);
    wait_until_drained();
    test_random_traffic(900);
    wait_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (failures == 0 && expected_replies.size() == 0)
      $display("tb_sorted_key_table: clean");
    else
      $display("tb_sorted_key_table: errors");
    $finish;
  end

  // Receiver: after each reply, either stays ready or holds the next reply back once
  // it is offered.
  initial begin
    int unsigned stall;
    forever begin
      @(negedge clk);
      stall = steady_flow ? 0 : $urandom_range(0, 4);
      if (stall != 0) begin
        m_tready <= 1'b0;
        do @(posedge clk); while (rst || m_tvalid !== 1'b1);
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (rst || m_tvalid !== 1'b1);
    end
  end

  // Compares every reply beat with the oldest prediction.
  always @(posedge clk) begin : check_reply
    table_reply_t got;
    table_reply_t want;
    if (!rst && m_tvalid === 1'b1 && m_tready === 1'b1) begin
      got.status = status_t'(m_tdata[1:0]);
      got.pos    = m_tdata[7:2];
      got.key    = m_tdata[39:8];
      got.hdl    = m_tdata[71:40];
      got.count  = m_tdata[78:72];
      if (expected_replies.size() == 0) begin
        if (failures < 10)
          $display("[%0t] reply with none pending: status %0d pos %0d key %h hdl %h count %0d",
                   $realtime, got.status, got.pos, got.key, got.hdl, got.count);
        failures++;
      end else begin
        want = expected_replies.pop_front();
        if (got !== want) begin
          if (failures < 10) begin
            $display("[%0t] reply mismatch", $realtime);
            $display("  expected status %0d pos %0d key %h hdl %h count %0d",
                     want.status, want.pos, want.key, want.hdl, want.count);
            $display("  actual   status %0d pos %0d key %h hdl %h count %0d",
                     got.status, got.pos, got.key, got.hdl, got.count);
          end
          failures++;
        end
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready === 1'b1) || (m_tvalid === 1'b1 && m_tready)) quiet = 0;
      else quiet++;
    end
    $display("tb_sorted_key_table: errors");
    $finish;
  end

endmodule
